// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_LEN     = 4'd1,
        PH_EXT_HI  = 4'd2,
        PH_EXT_LO  = 4'd3,
        PH_MASK    = 4'd4,
        PH_PAYLOAD = 4'd5
    } t_phase;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_CLOSE   = 3'd1,
        K_PING    = 3'd2,
        K_PONG    = 3'd3,
        K_UNKNOWN = 3'd4,
        K_LENBAD  = 3'd5
    } t_kind;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } t_in_beat;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic       last;
        logic [3:0] frame_opcode;
    } t_result;

    function automatic logic is_data_op(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY);
    endfunction

    function automatic logic is_ctrl_op(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

    function automatic t_kind ctrl_kind(input logic [3:0] op);
        t_kind k;
        unique case (op)
            OP_CLOSE: k = K_CLOSE;
            OP_PING:  k = K_PING;
            default:  k = K_PONG;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/wsd_ifs.sv =====
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       last;
    logic [3:0] frame_opcode;

    modport source (output valid, output kind, output payload_byte, output last,
                    output frame_opcode, input ready);
    modport sink (input valid, input kind, input payload_byte, input last,
                  input frame_opcode, output ready);
endinterface

// ===== rtl/wsd_in_stage.sv =====
module wsd_in_stage
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsd_in_if.sink     i_rx,
    input  logic       i_take,
    output logic       o_valid,
    output t_in_beat   o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    // hold the beat until the parser takes it
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_beat.rx_byte <= i_rx.rx_byte;
            r_beat.restart <= i_rx.restart;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== rtl/wsd_parser.sv =====
module wsd_parser
    import wsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_beat i_beat,
    output logic     o_res_valid,
    output t_result  o_res
);

    t_phase       r_phase, n_phase;
    logic [3:0]   r_opcode, n_opcode;
    logic         r_final, n_final;
    logic         r_mask_on, n_mask_on;
    logic [15:0]  r_remaining, n_remaining;
    logic [7:0]   r_len_hi, n_len_hi;
    logic [1:0]   r_kidx, n_kidx;
    logic [7:0]   r_key [4];

    t_phase       eph;
    logic [7:0]   b;
    logic [6:0]   len7;
    logic         key_we;

    assign b    = i_beat.rx_byte;
    assign len7 = b[6:0];
    assign eph  = i_beat.restart ? PH_HEADER : r_phase;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_final     = r_final;
        n_mask_on   = r_mask_on;
        n_remaining = r_remaining;
        n_len_hi    = r_len_hi;
        n_kidx      = r_kidx;
        key_we      = 1'b0;
        unique case (eph)
            PH_LEN: begin
                n_mask_on = b[7];
                if (len7 == LEN_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else if (len7 == LEN_EXT64) begin
                    n_phase = PH_HEADER;
                end else begin
                    n_remaining = {9'd0, len7};
                    n_kidx      = 2'd0;
                    if (b[7]) begin
                        n_phase = PH_MASK;
                    end else begin
                        n_phase = (len7 == 7'd0) ? PH_HEADER : PH_PAYLOAD;
                    end
                end
            end
            PH_EXT_HI: begin
                n_len_hi = b;
                n_phase  = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                n_remaining = {r_len_hi, b};
                n_kidx      = 2'd0;
                if (r_mask_on) begin
                    n_phase = PH_MASK;
                end else begin
                    n_phase = ({r_len_hi, b} == 16'd0) ? PH_HEADER : PH_PAYLOAD;
                end
            end
            PH_MASK: begin
                key_we = 1'b1;
                n_kidx = r_kidx + 2'd1;
                if (r_kidx == 2'd3) begin
                    n_phase = (r_remaining == 16'd0) ? PH_HEADER : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_kidx      = r_kidx + 2'd1;
                n_remaining = r_remaining - 16'd1;
                if (r_remaining == 16'd1) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_opcode    = b[3:0];
                n_final     = b[7];
                n_mask_on   = 1'b0;
                n_remaining = 16'd0;
                n_kidx      = 2'd0;
                n_phase     = (is_data_op(b[3:0]) || is_ctrl_op(b[3:0])) ? PH_LEN
                                                                         : PH_HEADER;
            end
        endcase
    end

    // result
    always_comb begin
        o_res_valid        = 1'b0;
        o_res.kind         = K_DATA;
        o_res.payload_byte = 8'd0;
        o_res.last         = 1'b0;
        o_res.frame_opcode = n_opcode;
        unique case (eph)
            PH_LEN: begin
                if (len7 == LEN_EXT64) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = K_LENBAD;
                end else if (len7 != LEN_EXT16 && !b[7] && is_ctrl_op(r_opcode)) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = ctrl_kind(r_opcode);
                end
            end
            PH_EXT_HI: begin
                o_res_valid = 1'b0;
            end
            PH_EXT_LO: begin
                if (!r_mask_on && is_ctrl_op(r_opcode)) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = ctrl_kind(r_opcode);
                end
            end
            PH_MASK: begin
                if (r_kidx == 2'd3 && is_ctrl_op(r_opcode)) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = ctrl_kind(r_opcode);
                end
            end
            PH_PAYLOAD: begin
                if (r_final && is_data_op(r_opcode)) begin
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = r_mask_on ? (b ^ r_key[r_kidx]) : b;
                    o_res.last         = (r_remaining == 16'd1);
                end
            end
            default: begin
                if (!(is_data_op(b[3:0]) || is_ctrl_op(b[3:0]))) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = K_UNKNOWN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_opcode    <= 4'd0;
            r_final     <= 1'b0;
            r_mask_on   <= 1'b0;
            r_remaining <= 16'd0;
            r_kidx      <= 2'd0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_opcode    <= n_opcode;
            r_final     <= n_final;
            r_mask_on   <= n_mask_on;
            r_remaining <= n_remaining;
            r_kidx      <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_len_hi <= n_len_hi;
            if (key_we) begin
                r_key[r_kidx] <= b;
            end
        end
    end

endmodule

// ===== rtl/wsd_out_stage.sv =====
module wsd_out_stage
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_res,
    output logic       o_can_take,
    wsd_out_if.source  o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_take = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.payload_byte = r_res.payload_byte;
    assign o_res.last         = r_res.last;
    assign o_res.frame_opcode = r_res.frame_opcode;

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// Path: a byte goes from the input register through the parser, and any result
//   it makes is loaded into the output register unless that register is held.
// Throughput: one byte per cycle unless held; one parser state update per beat.
// Reset: synchronous, active low; clears both stage valids and returns the
//   parser to waiting for a header byte.
module websocket_frame_deframer_top
    import wsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsd_in_if.sink     i_rx,
    wsd_out_if.source  o_res
);

    // Three parts: an input register, the parser (frame state plus the
    // unmask / event logic), and an output register. A beat moves out of
    // the input register whenever the output register can take a result,
    // whether or not that beat produces one, so header and key bytes never
    // stall the stream.

    logic     s1_valid;
    t_in_beat s1_beat;
    logic     out_can_take;
    logic     take;
    logic     res_valid;
    t_result  res;

    assign take = s1_valid && out_can_take;

    wsd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_beat  (s1_beat)
    );

    // Advance the frame state only on a taken beat.
    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (take),
        .i_beat      (s1_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Load a result only when the taken beat produced one; drop nothing.
    wsd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && res_valid),
        .i_res      (res),
        .o_can_take (out_can_take),
        .o_res      (o_res)
    );

endmodule
